// ===== rtl/bit_stuffing_serial_tx_core_macros.svh =====
// Assertion helpers shared by the transmitter modules.
// Both macros expect clk_i and rst_ni to exist in the module that uses them.
`ifndef BIT_STUFFING_SERIAL_TX_CORE_MACROS_SVH
`define BIT_STUFFING_SERIAL_TX_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bst assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define BST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bst assertion failed: next-cycle check");

`endif

// ===== rtl/bst_pkg.sv =====
package bst_pkg;

  // Run length of consecutive ones that triggers a stuffed zero (1 to 7).
  localparam int unsigned STUFF_RUN     = 5;
  // Upper bound on line bits produced by one input byte.
  localparam int unsigned MAX_RESULTS   = 10;
  localparam int unsigned BITS_PER_BYTE = 8;

  localparam int unsigned RUN_W = 3;
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 2);
  localparam int unsigned BIT_W = $clog2(BITS_PER_BYTE + 1);

  // Input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } bst_in_t;

  // Output beat, one per line bit.
  typedef struct packed {
    logic line_bit;
    logic stuffed;
    logic item_done;
    logic packet_done;
  } bst_out_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DATA,
    ST_STUFF
  } bst_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step_start;
    logic step_data;
    logic step_stuff;
  } bst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic can_step;
    logic first_in;
    logic stuff_hit;
    logic last_bit;
    logic bits_done;
  } bst_sts_t;

endpackage

// ===== rtl/bst_dpath.sv =====
module bst_dpath
  import bst_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bst_in_t  in_data_i,
  input  bst_cmd_t cmd_i,
  output bst_sts_t sts_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output bst_out_t out_data_o
);

  `include "bit_stuffing_serial_tx_core_macros.svh"

  logic [7:0]       sh_q, sh_d;
  logic             middle_q, middle_d;
  logic             last_q, last_d;
  logic [BIT_W-1:0] bitcnt_q, bitcnt_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [RUN_W-1:0] run_q, run_d;
  bst_out_t         out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [RUN_W-1:0] run_inc;
  logic [RUN_W-1:0] run_nx;
  logic [CNT_W-1:0] cnt_inc;
  logic             full;
  logic             stuff_hit;
  logic             last_bit;
  logic             bits_done;
  logic             stuff_follow;
  logic             emit;

  // Run tracking and per-byte position status.
  always_comb begin
    run_inc      = run_q + RUN_W'(1);
    run_nx       = sh_q[7] ? run_inc : '0;
    stuff_hit    = middle_q && (run_nx == RUN_W'(STUFF_RUN));
    cnt_inc      = cnt_q + CNT_W'(1);
    full         = (cnt_q == CNT_W'(MAX_RESULTS));
    last_bit     = (bitcnt_q == BIT_W'(BITS_PER_BYTE - 1));
    bits_done    = (bitcnt_q == BIT_W'(BITS_PER_BYTE));
    stuff_follow = stuff_hit && (cnt_inc < CNT_W'(MAX_RESULTS));
    emit         = (cmd_i.step_start || cmd_i.step_data || cmd_i.step_stuff) && !full;
  end

  assign sts_o.can_step  = !out_valid_q || out_ready_i || full;
  assign sts_o.first_in  = in_data_i.first_byte;
  assign sts_o.stuff_hit = stuff_hit;
  assign sts_o.last_bit  = last_bit;
  assign sts_o.bits_done = bits_done;

  // Next values of the working registers and the output beat.
  always_comb begin
    sh_d        = sh_q;
    middle_d    = middle_q;
    last_d      = last_q;
    bitcnt_d    = bitcnt_q;
    cnt_d       = cnt_q;
    run_d       = run_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.load) begin
      sh_d     = in_data_i.data_byte;
      middle_d = !in_data_i.first_byte && !in_data_i.last_byte;
      last_d   = in_data_i.last_byte;
      bitcnt_d = '0;
      cnt_d    = '0;
      if (in_data_i.first_byte) begin
        run_d = '0;
      end
    end

    if (cmd_i.step_data) begin
      sh_d     = {sh_q[6:0], 1'b0};
      bitcnt_d = bitcnt_q + BIT_W'(1);
      if (middle_q) begin
        run_d = stuff_hit ? '0 : run_nx;
      end
    end

    if (emit) begin
      cnt_d       = cnt_inc;
      out_valid_d = 1'b1;
      if (cmd_i.step_start) begin
        out_d.line_bit  = 1'b1;
        out_d.stuffed   = 1'b0;
        out_d.item_done = (cnt_inc == CNT_W'(MAX_RESULTS));
      end else if (cmd_i.step_data) begin
        out_d.line_bit  = sh_q[7];
        out_d.stuffed   = 1'b0;
        out_d.item_done = (last_bit && !stuff_follow) ||
                          (cnt_inc == CNT_W'(MAX_RESULTS));
      end else begin
        out_d.line_bit  = 1'b0;
        out_d.stuffed   = 1'b1;
        out_d.item_done = bits_done || (cnt_inc == CNT_W'(MAX_RESULTS));
      end
      out_d.packet_done = out_d.item_done && last_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitcnt_q    <= '0;
      cnt_q       <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bitcnt_q    <= bitcnt_d;
      cnt_q       <= cnt_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sh_q     <= sh_d;
    middle_q <= middle_d;
    last_q   <= last_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A stuffed bit is always a zero, and a packet end is also a byte end.
  `BST_ASSERT_NOW(a_stuff_is_zero, out_valid_q && out_q.stuffed, !out_q.line_bit)
  `BST_ASSERT_NOW(a_pkt_ends_item, out_valid_q && out_q.packet_done, out_q.item_done)
  // The run counter is cleared whenever it reaches the stuffing length.
  `BST_ASSERT_NOW(a_run_below_limit, 1'b1, run_q < RUN_W'(STUFF_RUN))
  // No byte produces more beats than the limit.
  `BST_ASSERT_NOW(a_cnt_bounded, 1'b1, cnt_q <= CNT_W'(MAX_RESULTS))

endmodule

// ===== rtl/bst_ctrl.sv =====
module bst_ctrl
  import bst_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bst_sts_t sts_i,
  output bst_cmd_t cmd_o
);

  `include "bit_stuffing_serial_tx_core_macros.svh"

  bst_state_e state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.first_in ? ST_START : ST_DATA;
        end
      end
      ST_START: begin
        if (sts_i.can_step) begin
          state_d = ST_DATA;
        end
      end
      ST_DATA: begin
        if (sts_i.can_step) begin
          priority if (sts_i.stuff_hit) begin
            state_d = ST_STUFF;
          end else if (sts_i.last_bit) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_DATA;
          end
        end
      end
      ST_STUFF: begin
        if (sts_i.can_step) begin
          state_d = sts_i.bits_done ? ST_IDLE : ST_DATA;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_START: cmd_o.step_start = sts_i.can_step;
      ST_DATA:  cmd_o.step_data  = sts_i.can_step;
      ST_STUFF: cmd_o.step_stuff = sts_i.can_step;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted byte always starts work on the next cycle.
  `BST_ASSERT_NEXT(a_load_leaves_idle, cmd_o.load, state_q != ST_IDLE)
  // A stuffed zero is entered only from a data bit; it may hold while the output stalls.
  `BST_ASSERT_NEXT(a_stuff_after_data, state_q != ST_DATA && state_q != ST_STUFF,
                   state_q != ST_STUFF)

endmodule

// ===== rtl/bit_stuffing_serial_tx_core.sv =====
// The first line bit of a byte is registered at the output once the sequencer steps it out of ST_START or ST_DATA.
// Throughput: one line bit per cycle while the output is not stalled; a byte gives a start bit (first
// bytes only), eight data bits and any stuffed zeros, set by the single-bit sequencer.
// The next byte is accepted while the last bit of the previous one waits at the output.
// Reset (rst_ni low, asynchronous) returns to idle, clears the ones run and the output valid.
module bit_stuffing_serial_tx_core
  import bst_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bst_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bst_out_t out_data_o
);

  bst_cmd_t cmd;
  bst_sts_t sts;

  // Sequencer.
  bst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Shift register, run counter and output register.
  bst_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/bit_stuffing_serial_tx_core_tb.sv =====
`timescale 1ns / 100ps

module bit_stuffing_serial_tx_core_tb;
  import bst_pkg::*;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  bst_in_t  in_beat   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bst_out_t out_beat;

  // Bytes waiting to be sent and line bits waiting to be seen.
  bst_in_t  byte_q[$];
  bst_out_t line_bits_q[$];

  // Predicted ones run, kept in step with the transmitter.
  logic [RUN_W-1:0] ones_cnt = '0;

  // Idle and stall odds, in percent, for the current phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_cnt   = 0;

  bst_out_t got_bit;
  bst_out_t want_bit;

  bit_stuffing_serial_tx_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_beat)
  );

  // Clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Expands one byte into its line bits: start bit, MSB-first data, stuffed zeros.
  function automatic void predict_line_bits(bst_in_t beat);
    bst_out_t   bits[$];
    bst_out_t   b;
    logic [7:0] shreg;
    logic       mid;
    logic       cur;
    shreg = beat.data_byte;
    mid   = !beat.first_byte && !beat.last_byte;
    if (beat.first_byte) begin
      ones_cnt = '0;
      b = '0;
      b.line_bit = 1'b1;
      bits.push_back(b);
    end
    for (int k = 0; k < BITS_PER_BYTE; k++) begin
      cur = shreg[7];
      b = '0;
      b.line_bit = cur;
      if (bits.size() < MAX_RESULTS) bits.push_back(b);
      // Only middle bytes count toward the run; flags pass through untouched.
      if (mid) begin
        ones_cnt = cur ? ones_cnt + 1'b1 : '0;
        if (ones_cnt == RUN_W'(STUFF_RUN)) begin
          ones_cnt = '0;
          b = '0;
          b.stuffed = 1'b1;
          if (bits.size() < MAX_RESULTS) bits.push_back(b);
        end
      end
      shreg = shreg << 1;
    end
    if (bits.size() > 0) begin
      bits[bits.size()-1].item_done   = 1'b1;
      bits[bits.size()-1].packet_done = beat.last_byte;
    end
    foreach (bits[i]) line_bits_q.push_back(bits[i]);
  endfunction

  // Driver: holds each beat until it is taken, then offers the next one or idles.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_beat  <= '0;
    end else if (!in_valid || in_ready) begin
      if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_beat  <= byte_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on each accepted byte and checks each accepted line bit.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_line_bits(in_beat);
      if (out_valid && out_ready) begin
        got_bit = out_beat;
        if (line_bits_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected line bit %b (bit/stuffed/item/packet)", $time, got_bit);
        end else begin
          want_bit = line_bits_q.pop_front();
          if (got_bit.line_bit    !== want_bit.line_bit    ||
              got_bit.stuffed     !== want_bit.stuffed     ||
              got_bit.item_done   !== want_bit.item_done   ||
              got_bit.packet_done !== want_bit.packet_done) begin
            mismatch_cnt++;
            $display("%0t: line bit mismatch, expected bit=%b stuffed=%b item=%b packet=%b",
                     $time, want_bit.line_bit, want_bit.stuffed, want_bit.item_done,
                     want_bit.packet_done);
            $display("%0t:                    actual   bit=%b stuffed=%b item=%b packet=%b",
                     $time, got_bit.line_bit, got_bit.stuffed, got_bit.item_done,
                     got_bit.packet_done);
          end
        end
      end
    end
  end

  function automatic void push_byte(logic [7:0] data, logic first, logic last);
    bst_in_t beat;
    beat.data_byte  = data;
    beat.first_byte = first;
    beat.last_byte  = last;
    byte_q.push_back(beat);
  endfunction

  // Random byte content, often dense in ones so that stuffing is hit.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(3))
      0: return 8'hFF;
      1: return 8'($urandom_range(255) | $urandom_range(255));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed packets, with some stray flags and orphan bytes mixed in.
  task automatic fill_random(int unsigned n_bytes);
    int unsigned cnt;
    int unsigned n_mid;
    cnt = 0;
    while (cnt < n_bytes) begin
      if ($urandom_range(99) < 80) begin
        n_mid = $urandom_range(5);
        if ($urandom_range(9) == 0) begin
          push_byte(rand_byte(), 1'b1, 1'b1);
          cnt += 1;
        end else begin
          push_byte(rand_byte(), 1'b1, 1'b0);
          repeat (n_mid) push_byte(rand_byte(), 1'b0, 1'b0);
          push_byte(rand_byte(), 1'b0, 1'b1);
          cnt += n_mid + 2;
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          push_byte(rand_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)));
          cnt += 1;
        end
      end
    end
  endtask

  // Lets the queued bytes go out, then waits until every line bit is back.
  task automatic drain();
    while (byte_q.size() > 0 || in_valid) @(negedge clk);
    while (line_bits_q.size() > 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, no idling.
    push_byte(8'hF8, 1'b0, 1'b0);  // middle byte with no packet open
    push_byte(8'h7E, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);  // run carries over from the previous byte
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h1F, 1'b0, 1'b0);  // stuffed zero lands on the last bit
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'h3E, 1'b0, 1'b0);
    push_byte(8'h01, 1'b0, 1'b0);
    push_byte(8'h7E, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);  // first and last together
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);  // repeated first byte restarts the packet
    push_byte(8'hAA, 1'b0, 1'b0);
    push_byte(8'h55, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h7E, 1'b1, 1'b0);  // restart while a run is held
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);  // last byte with no packet open
    push_byte(8'h0F, 1'b0, 1'b0);
    push_byte(8'hF0, 1'b0, 1'b0);
    push_byte(8'h7E, 1'b0, 1'b1);
    drain();

    // Random part over the idling phases.
    set_idling(0, 0);
    fill_random(48);
    drain();
    set_idling(62, 0);
    fill_random(48);
    drain();
    set_idling(0, 62);
    fill_random(48);
    drain();
    set_idling(21, 21);
    fill_random(48);
    drain();

    if (mismatch_cnt == 0 && line_bits_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
